// ----- rtl/core/msd_pkg.sv -----
package msd_pkg;

  // Number of debounced switches; switch 0 is the button.
  localparam int NUM_SWITCHES = 5;
  localparam int SENSOR_BITS  = NUM_SWITCHES + 1;
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] SAMPLE_PERIOD_RST = 8'd10;
  localparam logic [CNT_W-1:0] STABLE_READS_RST  = 8'd3;
  localparam logic             PRESSED_LEVEL_RST = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_STABLE_READS  = 2'd1,
    CFG_PRESSED_LEVEL = 2'd2
  } msd_cfg_idx_t;

  // One input item: one system tick.
  typedef struct packed {
    logic [NUM_SWITCHES-1:0] raw_levels;
    logic                    led_level;
  } msd_in_t;

  // One result item.
  typedef struct packed {
    logic [SENSOR_BITS-1:0] sensor_byte;
    logic [7:0]             button_presses;
    logic                   sample_taken;
  } msd_out_t;

  // Control shared by all switch lanes for one tick.
  typedef struct packed {
    logic             step;
    logic             sample;
    logic [CNT_W-1:0] stable_reads;
    logic             pressed_level;
  } msd_lane_ctrl_t;

  // What one lane reports back for the current tick.
  typedef struct packed {
    logic stable_nxt;
    logic press;
  } msd_lane_stat_t;

endpackage

// ----- rtl/core/msd_prescaler.sv -----
module msd_prescaler import msd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [CNT_W-1:0] sample_period,
  output logic             sample
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // The counter only runs while nonzero; a step at one samples and reloads.
  always_comb begin
    sample    = 1'b0;
    count_nxt = count_r;
    if (step && (count_r != '0)) begin
      if (count_r == CNT_W'(1)) begin
        sample    = 1'b1;
        count_nxt = sample_period;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= SAMPLE_PERIOD_RST;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/msd_lane.sv -----
module msd_lane import msd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  msd_lane_ctrl_t ctrl,
  input  logic           lvl,
  output msd_lane_stat_t stat
);

  logic             last_r;
  logic             last_nxt;
  logic [CNT_W-1:0] agree_r;
  logic [CNT_W-1:0] agree_nxt;
  logic             stable_r;
  logic             stable_nxt;
  logic [CNT_W-1:0] agree_inc;
  logic             press;

  assign agree_inc = agree_r + CNT_W'(1);

  // An equal sample advances agreement; a differing one restarts it.
  always_comb begin
    last_nxt   = last_r;
    agree_nxt  = agree_r;
    stable_nxt = stable_r;
    press      = 1'b0;
    if (ctrl.step && ctrl.sample) begin
      if (lvl == last_r) begin
        agree_nxt = agree_inc;
        if (agree_inc == ctrl.stable_reads) begin
          press      = (stable_r == ~ctrl.pressed_level) && (lvl == ctrl.pressed_level);
          stable_nxt = lvl;
          agree_nxt  = '0;
        end
      end else begin
        last_nxt  = lvl;
        agree_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b0;
      agree_r  <= '0;
      stable_r <= 1'b0;
    end else begin
      last_r   <= last_nxt;
      agree_r  <= agree_nxt;
      stable_r <= stable_nxt;
    end
  end

  assign stat.stable_nxt = stable_nxt;
  assign stat.press      = press;

endmodule

// ----- rtl/core/multi_switch_debouncer_top.sv -----
// An item goes through the tick register, then the result register, to out_data.
// Throughput: one item per cycle while out_ready is high; the two registers form
// a two-stage pipeline, and all switch lanes update in parallel.
// Reset (rst_n, synchronous, active low) restores the configuration registers,
// reloads the prescaler to 10 and clears all switch state and the press count.
module multi_switch_debouncer_top import msd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  msd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output msd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] sample_period_r;
  logic [CNT_W-1:0] stable_reads_r;
  logic             pressed_level_r;

  logic             s1_valid_r;
  msd_in_t          s1_data_r;
  logic             out_valid_r;
  msd_out_t         out_data_r;
  logic [7:0]       press_count_r;
  logic [7:0]       press_count_nxt;

  logic             s1_adv;
  logic             sample;
  msd_lane_ctrl_t   lane_ctrl;
  msd_lane_stat_t   lane_stat [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0] stable_nxt;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SAMPLE_PERIOD_RST;
      stable_reads_r  <= STABLE_READS_RST;
      pressed_level_r <= PRESSED_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata[CNT_W-1:0];
        CFG_STABLE_READS:  stable_reads_r  <= cfg_wdata[CNT_W-1:0];
        CFG_PRESSED_LEVEL: pressed_level_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the tick stage moves on when the result register frees up.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Prescaler decides whether this tick samples the switches.
  msd_prescaler u_prescaler (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_adv),
    .sample_period (sample_period_r),
    .sample        (sample)
  );

  assign lane_ctrl.step          = s1_adv;
  assign lane_ctrl.sample        = sample;
  assign lane_ctrl.stable_reads  = stable_reads_r;
  assign lane_ctrl.pressed_level = pressed_level_r;

  // One debounce lane per switch.
  for (genvar k = 0; k < NUM_SWITCHES; k++) begin : g_lane
    msd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .lvl   (s1_data_r.raw_levels[k]),
      .stat  (lane_stat[k])
    );
    assign stable_nxt[k] = lane_stat[k].stable_nxt;
  end

  // Only the button lane counts presses.
  assign press_count_nxt = press_count_r + {7'd0, lane_stat[0].press};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_count_r <= '0;
    end else begin
      press_count_r <= press_count_nxt;
    end
  end

  // Result register, loaded with the state after this tick's update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.sensor_byte    <= {s1_data_r.led_level, stable_nxt};
      out_data_r.button_presses <= press_count_nxt;
      out_data_r.sample_taken   <= sample;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The press count moves only on a sampling tick.
  a_press_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_adv || !sample) |=> (press_count_r == $past(press_count_r)))
    else $error("press count changed without a sample");

  // The press count advances by at most one per tick.
  a_press_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> ((press_count_r == $past(press_count_r)) ||
                (press_count_r == $past(press_count_r) + 8'd1)))
    else $error("press count jumped");

  // A tick that leaves the first stage always lands in the result register.
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced tick lost");

  // The stored result follows the press count it was computed with.
  a_out_presses: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_data_r.button_presses == press_count_r))
    else $error("result press count mismatch");

endmodule
